// ===== src/stxenc_pkg.sv =====
// shared types and constants for the stx/etx/dle frame encoder
package stxenc_pkg;

  localparam int FieldBytes = 18;
  localparam int IdxW = $clog2(FieldBytes + 3);
  localparam int ByteIdxW = $clog2(FieldBytes);

  // token order inside one frame: start, field bytes, end, check
  localparam logic [IdxW-1:0] TokStart = IdxW'(0);
  localparam logic [IdxW-1:0] TokEnd = IdxW'(FieldBytes + 1);
  localparam logic [IdxW-1:0] TokCheck = IdxW'(FieldBytes + 2);

  localparam int QueueDepth = 4;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int CountW = $clog2(QueueDepth + 1);

  localparam logic [1:0] RegStart = 2'd0;
  localparam logic [1:0] RegEnd = 2'd1;
  localparam logic [1:0] RegEscape = 2'd2;

  localparam logic [7:0] StartReset = 8'h02;
  localparam logic [7:0] EndReset = 8'h03;
  localparam logic [7:0] EscapeReset = 8'h10;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
  } codes_t;

  typedef struct packed {
    logic [7:0] value;
    logic       esc;
    logic       last;
  } tok_t;

endpackage

// ===== src/stx_etx_dle_frame_encoder_top.sv =====
// top level of the stx/etx/dle frame encoder
// after a packet request is accepted, its first token is written into the queue, then loaded into the output register
// throughput: one byte per cycle at the output while out_ready is high, through the
// single-byte output register; a frame is 21 to 39 bytes
// the front takes the next packet in the same cycle it pushes its 21st token, while bytes drain
// reset: synchronous; clears queue, handshakes and restores codes 0x02, 0x03, 0x10
module stx_etx_dle_frame_encoder_top import stxenc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] packet_id,
  input  logic [31:0] client_id,
  input  logic [15:0] op_code,
  input  logic [15:0] pin_number,
  input  logic [15:0] pin_mode,
  input  logic [31:0] payload_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  codes_t codes;
  logic   push;
  tok_t   push_tok;
  logic   q_full;
  logic   pop;
  logic   not_empty;
  tok_t   head;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.start_code <= StartReset;
      codes.end_code <= EndReset;
      codes.escape_code <= EscapeReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegStart: codes.start_code <= cfg_data;
        RegEnd: codes.end_code <= cfg_data;
        RegEscape: codes.escape_code <= cfg_data;
        default: ;
      endcase
    end
  end

  stxenc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .codes        (codes),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .packet_id    (packet_id),
    .client_id    (client_id),
    .op_code      (op_code),
    .pin_number   (pin_number),
    .pin_mode     (pin_mode),
    .payload_word (payload_word),
    .push         (push),
    .push_tok     (push_tok),
    .q_full       (q_full)
  );

  stxenc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  stxenc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .codes     (codes),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule

// ===== src/stxenc_front.sv =====
// front end: holds one packet and walks it into frame tokens with escape marks
module stxenc_front import stxenc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  codes_t      codes,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] packet_id,
  input  logic [31:0] client_id,
  input  logic [15:0] op_code,
  input  logic [15:0] pin_number,
  input  logic [15:0] pin_mode,
  input  logic [31:0] payload_word,
  output logic        push,
  output tok_t        push_tok,
  input  logic        q_full
);

  logic                busy;
  logic [IdxW-1:0]     idx;
  logic [7:0]          pkt [FieldBytes];
  logic [7:0]          check;
  logic [ByteIdxW-1:0] data_idx;
  logic [7:0]          data_byte;
  logic [FieldBytes*8-1:0] flat;
  logic                done;
  logic                accept;

  assign flat = {payload_word, pin_mode, pin_number, op_code, client_id, packet_id};

  assign push = busy && !q_full;
  assign done = push && (idx == TokCheck);
  assign in_ready = !busy || done;
  assign accept = in_valid && in_ready;

  assign data_idx = ByteIdxW'(idx - IdxW'(1));
  assign data_byte = pkt[data_idx];

  always_comb begin
    push_tok = '0;
    case (idx)
      TokStart: begin
        push_tok.value = codes.start_code;
      end
      TokEnd: begin
        push_tok.value = codes.end_code;
      end
      TokCheck: begin
        push_tok.value = check;
        push_tok.last = 1'b1;
      end
      default: begin
        push_tok.value = data_byte;
        push_tok.esc = (data_byte == codes.start_code) || (data_byte == codes.end_code) ||
                       (data_byte == codes.escape_code);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= TokStart;
    end else if (accept) begin
      busy <= 1'b1;
      idx <= TokStart;
    end else if (push) begin
      if (done) begin
        busy <= 1'b0;
      end
      idx <= idx + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < FieldBytes; i++) begin
        pkt[i] <= flat[i*8 +: 8];
      end
      check <= {pin_number[3:0], pin_mode[3:0]};
    end
  end

endmodule

// ===== src/stxenc_queue.sv =====
// small token queue between front and back
module stxenc_queue import stxenc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output tok_t head
);

  tok_t              mem [QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  assign full = (count == CountW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CountW'(1);
      end else if (pop && !push) begin
        count <= count - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

endmodule

// ===== src/stxenc_back.sv =====
// back end: expands tokens into bytes, inserting escapes, into the output register
module stxenc_back import stxenc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  codes_t     codes,
  input  logic       not_empty,
  input  tok_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_byte
);

  logic esc_sent;
  logic load;
  logic send_esc;

  assign load = not_empty && (!out_valid || out_ready);
  // an escaped token becomes two bytes: escape first, then the byte itself
  assign send_esc = head.esc && !esc_sent;
  assign pop = load && !send_esc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      esc_sent <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        esc_sent <= send_esc;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= send_esc ? codes.escape_code : head.value;
      last_byte <= send_esc ? 1'b0 : head.last;
    end
  end

endmodule
